/* hw/rtl/edts_pkg.sv */
// Package: constants and codes for the elevator door and travel sequencer.
package edts_pkg;

    localparam int FLOOR_W     = 5;
    localparam int FLOOR_COUNT = 16;
    localparam int TICKS_W     = 21;
    localparam int WIDTH_W     = 8;
    localparam int MS_W        = 16;
    localparam int POS_W       = 13;
    localparam int PROD_W      = TICKS_W + WIDTH_W;
    localparam int MUL_STEPS   = WIDTH_W;
    localparam int DIV_STEPS   = PROD_W;
    localparam int STEP_W      = 5;
    localparam int CFG_IDX_W   = 3;

    localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

    // cabin modes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_OPENING = 3'd1;
    localparam logic [2:0] MODE_BOARD   = 3'd2;
    localparam logic [2:0] MODE_CLOSING = 3'd3;
    localparam logic [2:0] MODE_MOVING  = 3'd4;
    localparam logic [2:0] MODE_ARRIVED = 3'd5;
    localparam logic [2:0] MODE_CLOSE2  = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DOOR_FULL_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOOR_MOVE_MS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOARDING_WAIT_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVAL_HOLD_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PER_FLOOR_MS     = 3'd4;

    // sequencer states
    localparam logic [1:0] SEQ_IDLE = 2'd0;
    localparam logic [1:0] SEQ_MUL  = 2'd1;
    localparam logic [1:0] SEQ_DIV  = 2'd2;
    localparam logic [1:0] SEQ_DONE = 2'd3;

endpackage

/* hw/rtl/elevator_door_travel_sequencer.sv */
// Elevator door/travel sequencer: one tick per transfer, serial shift-add multiply and divide.
// Ticks needing no arithmetic (idle, boarding) go straight to the finalize step; others run
// 8 multiply steps, 29 restoring divide steps and 1 finalize step; a moving tick that arrives
// skips the divide. One tick is in work at a time.
// The result register lets the next tick be taken while a result waits.
// Reset (aresetn low, synchronous): idle, floor 1, counters clear, registers to defaults.
module elevator_door_travel_sequencer
    import edts_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MS_W-1:0]      cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_call_valid,
    input  logic [FLOOR_W-1:0]   s_call_floor,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_mode_code,
    output logic [WIDTH_W-1:0]   m_door_width,
    output logic [FLOOR_W-1:0]   m_floor_now,
    output logic [POS_W-1:0]     m_visual_floor_q8,
    output logic                 m_ride_started,
    output logic [FLOOR_W-1:0]   m_ride_floor
);

    // configuration
    logic [WIDTH_W-1:0] full_w_reg;
    logic [MS_W-1:0]    move_ms_reg, board_ms_reg, hold_ms_reg, floor_ms_reg;

    // architectural state
    logic [2:0]         mode_reg, mode_next;
    logic [FLOOR_W-1:0] present_reg, present_next;
    logic [FLOOR_W-1:0] goal_reg, goal_next;
    logic [TICKS_W-1:0] ticks_reg, ticks_next;

    // sequencer and datapath
    logic [1:0]         seq_reg, seq_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               call_valid_reg, call_valid_next;
    logic [FLOOR_W-1:0] call_floor_reg, call_floor_next;
    logic [TICKS_W-1:0] elapsed_reg, elapsed_next;
    logic [TICKS_W-1:0] mcand_reg, mcand_next;
    logic [WIDTH_W-1:0] mplier_reg, mplier_next;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [PROD_W-1:0]  dvd_reg, dvd_next;
    logic [MS_W-1:0]    rem_reg, rem_next;
    logic [MS_W-1:0]    dvsr_reg, dvsr_next;
    logic               arrived_reg, arrived_next;

    // result register
    logic               m_valid_reg, m_valid_next;
    logic [2:0]         out_mode_reg, out_mode_next;
    logic [WIDTH_W-1:0] out_door_reg, out_door_next;
    logic [FLOOR_W-1:0] out_floor_reg, out_floor_next;
    logic [POS_W-1:0]   out_vis_reg, out_vis_next;
    logic               out_start_reg, out_start_next;
    logic [FLOOR_W-1:0] out_ride_reg, out_ride_next;

    logic               in_xfer;
    logic [TICKS_W-1:0] elapsed_sat;
    logic               going_up;
    logic [FLOOR_W-1:0] floor_diff;
    logic [PROD_W-1:0]  acc_step;
    logic [MS_W:0]      div_part;
    logic [MS_W:0]      div_trial;
    logic               div_ge;
    logic [PROD_W-1:0]  quot;
    logic               ramp_done;
    logic [FLOOR_W-1:0] clamped_floor;
    logic [POS_W-1:0]   base_pos;

    assign s_ready = (seq_reg == SEQ_IDLE);
    assign in_xfer = s_valid && s_ready;

    assign elapsed_sat = (ticks_reg == TICKS_MAX) ? TICKS_MAX : ticks_reg + 1'b1;
    assign going_up    = goal_reg > present_reg;
    assign floor_diff  = going_up ? goal_reg - present_reg : present_reg - goal_reg;

    // MSB-first shift-add multiply step
    assign acc_step = {acc_reg[PROD_W-2:0], 1'b0}
                    + (mplier_reg[WIDTH_W-1] ? {{(PROD_W-TICKS_W){1'b0}}, mcand_reg}
                                             : {PROD_W{1'b0}});

    // restoring divide step, one quotient bit per cycle
    assign div_part  = {rem_reg, dvd_reg[PROD_W-1]};
    assign div_trial = div_part - {1'b0, dvsr_reg};
    assign div_ge    = div_part >= {1'b0, dvsr_reg};

    assign quot      = dvd_reg;
    assign ramp_done = quot >= {{(PROD_W-WIDTH_W){1'b0}}, full_w_reg};
    assign base_pos  = {present_reg, 8'd0};

    always_comb begin
        if (call_floor_reg == '0) begin
            clamped_floor = FLOOR_W'(1);
        end else if (call_floor_reg > FLOOR_W'(FLOOR_COUNT)) begin
            clamped_floor = FLOOR_W'(FLOOR_COUNT);
        end else begin
            clamped_floor = call_floor_reg;
        end
    end

    always_comb begin
        seq_next        = seq_reg;
        step_next       = step_reg;
        call_valid_next = call_valid_reg;
        call_floor_next = call_floor_reg;
        elapsed_next    = elapsed_reg;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        acc_next        = acc_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        dvsr_next       = dvsr_reg;
        arrived_next    = arrived_reg;
        mode_next       = mode_reg;
        present_next    = present_reg;
        goal_next       = goal_reg;
        ticks_next      = ticks_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_mode_next   = out_mode_reg;
        out_door_next   = out_door_reg;
        out_floor_next  = out_floor_reg;
        out_vis_next    = out_vis_reg;
        out_start_next  = out_start_reg;
        out_ride_next   = out_ride_reg;

        unique case (seq_reg)
            SEQ_IDLE: begin
                if (in_xfer) begin
                    call_valid_next = s_call_valid;
                    call_floor_next = s_call_floor;
                    elapsed_next    = elapsed_sat;
                    acc_next        = '0;
                    step_next       = '0;
                    arrived_next    = 1'b0;
                    if (mode_reg == MODE_MOVING) begin
                        mcand_next  = {{(TICKS_W-MS_W){1'b0}}, floor_ms_reg};
                        mplier_next = {{(WIDTH_W-FLOOR_W){1'b0}}, floor_diff};
                    end else begin
                        mcand_next  = elapsed_sat;
                        mplier_next = full_w_reg;
                    end
                    if (mode_reg == MODE_OPENING || mode_reg == MODE_CLOSING ||
                        mode_reg == MODE_MOVING || mode_reg == MODE_ARRIVED ||
                        mode_reg == MODE_CLOSE2) begin
                        seq_next = SEQ_MUL;
                    end else begin
                        seq_next = SEQ_DONE;
                    end
                end
            end
            SEQ_MUL: begin
                acc_next    = acc_step;
                mplier_next = {mplier_reg[WIDTH_W-2:0], 1'b0};
                step_next   = step_reg + 1'b1;
                if (step_reg == STEP_W'(MUL_STEPS - 1)) begin
                    step_next = '0;
                    rem_next  = '0;
                    if (mode_reg == MODE_MOVING) begin
                        dvd_next  = {elapsed_reg, 8'd0};
                        dvsr_next = floor_ms_reg;
                        if ({{(PROD_W-TICKS_W){1'b0}}, elapsed_reg} >= acc_step) begin
                            arrived_next = 1'b1;
                            seq_next     = SEQ_DONE;
                        end else begin
                            seq_next = SEQ_DIV;
                        end
                    end else begin
                        dvd_next  = acc_step;
                        // zero door time divides by one
                        dvsr_next = (move_ms_reg == '0) ? MS_W'(1) : move_ms_reg;
                        seq_next  = SEQ_DIV;
                    end
                end
            end
            SEQ_DIV: begin
                rem_next  = div_ge ? div_trial[MS_W-1:0] : div_part[MS_W-1:0];
                dvd_next  = {dvd_reg[PROD_W-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    seq_next = SEQ_DONE;
                end
            end
            SEQ_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    seq_next       = SEQ_IDLE;
                    m_valid_next   = 1'b1;
                    ticks_next     = elapsed_reg;
                    out_start_next = 1'b0;
                    out_ride_next  = '0;
                    out_vis_next   = base_pos;
                    unique case (mode_reg)
                        MODE_OPENING: begin
                            if (ramp_done) begin
                                out_door_next = full_w_reg;
                                mode_next     = MODE_BOARD;
                                ticks_next    = '0;
                            end else begin
                                out_door_next = quot[WIDTH_W-1:0];
                            end
                        end
                        MODE_BOARD: begin
                            out_door_next = full_w_reg;
                            if ({{(TICKS_W-MS_W){1'b0}}, board_ms_reg} <= elapsed_reg) begin
                                mode_next  = MODE_CLOSING;
                                ticks_next = '0;
                            end
                        end
                        MODE_CLOSING, MODE_CLOSE2: begin
                            if (ramp_done) begin
                                out_door_next = '0;
                                ticks_next    = '0;
                                if (mode_reg == MODE_CLOSE2) begin
                                    mode_next = MODE_IDLE;
                                end else if (present_reg == goal_reg) begin
                                    mode_next = MODE_ARRIVED;
                                end else begin
                                    mode_next = MODE_MOVING;
                                end
                            end else begin
                                out_door_next = full_w_reg - quot[WIDTH_W-1:0];
                            end
                        end
                        MODE_MOVING: begin
                            out_door_next = '0;
                            if (arrived_reg) begin
                                present_next = goal_reg;
                                out_vis_next = {goal_reg, 8'd0};
                                mode_next    = MODE_ARRIVED;
                                ticks_next   = '0;
                            end else if (going_up) begin
                                out_vis_next = base_pos + quot[POS_W-1:0];
                            end else begin
                                out_vis_next = base_pos - quot[POS_W-1:0];
                            end
                        end
                        MODE_ARRIVED: begin
                            if (elapsed_reg <= {{(TICKS_W-MS_W){1'b0}}, move_ms_reg}) begin
                                out_door_next = quot[WIDTH_W-1:0];
                            end else begin
                                out_door_next = full_w_reg;
                            end
                            if ({{(TICKS_W-MS_W){1'b0}}, hold_ms_reg} <= elapsed_reg) begin
                                mode_next  = MODE_CLOSE2;
                                ticks_next = '0;
                            end
                        end
                        default: begin
                            // idle, and the unused code handled as idle
                            out_door_next = '0;
                            if (call_valid_reg) begin
                                goal_next      = clamped_floor;
                                out_start_next = 1'b1;
                                out_ride_next  = clamped_floor;
                                mode_next      = MODE_OPENING;
                                ticks_next     = '0;
                            end
                        end
                    endcase
                    out_mode_next  = mode_next;
                    out_floor_next = present_next;
                end
            end
            default: begin
                seq_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_w_reg    <= WIDTH_W'(120);
            move_ms_reg   <= MS_W'(1000);
            board_ms_reg  <= MS_W'(2000);
            hold_ms_reg   <= MS_W'(3000);
            floor_ms_reg  <= MS_W'(1500);
            mode_reg      <= MODE_IDLE;
            present_reg   <= FLOOR_W'(1);
            goal_reg      <= FLOOR_W'(1);
            ticks_reg     <= '0;
            seq_reg       <= SEQ_IDLE;
            step_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_DOOR_FULL_WIDTH:  full_w_reg   <= cfg_wdata[WIDTH_W-1:0];
                    REG_DOOR_MOVE_MS:     move_ms_reg  <= cfg_wdata;
                    REG_BOARDING_WAIT_MS: board_ms_reg <= cfg_wdata;
                    REG_ARRIVAL_HOLD_MS:  hold_ms_reg  <= cfg_wdata;
                    REG_PER_FLOOR_MS:     floor_ms_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            mode_reg    <= mode_next;
            present_reg <= present_next;
            goal_reg    <= goal_next;
            ticks_reg   <= ticks_next;
            seq_reg     <= seq_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        call_valid_reg <= call_valid_next;
        call_floor_reg <= call_floor_next;
        elapsed_reg    <= elapsed_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        acc_reg        <= acc_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        dvsr_reg       <= dvsr_next;
        arrived_reg    <= arrived_next;
        out_mode_reg   <= out_mode_next;
        out_door_reg   <= out_door_next;
        out_floor_reg  <= out_floor_next;
        out_vis_reg    <= out_vis_next;
        out_start_reg  <= out_start_next;
        out_ride_reg   <= out_ride_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_mode_code       = out_mode_reg;
    assign m_door_width      = out_door_reg;
    assign m_floor_now       = out_floor_reg;
    assign m_visual_floor_q8 = out_vis_reg;
    assign m_ride_started    = out_start_reg;
    assign m_ride_floor      = out_ride_reg;

endmodule
